@@ design/ssd_pkg.sv @@
`default_nettype none

package ssd_pkg;

  // Display geometry and field widths.
  localparam int MAX_DIGITS = 8;
  localparam int DIGIT_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int COUNT_W    = 4;
  localparam int VALUE_W    = 27;
  localparam int LINES_W    = 8;
  localparam int BCD_W      = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  // Divide by ten through a reciprocal: q = (v * DIV10_MULT) >> DIV10_SHIFT
  // is exact for every v below 2**VALUE_W.
  localparam int DIV10_SHIFT = 30;
  localparam logic [VALUE_W-1:0] DIV10_MULT = 27'd107374183;

  // Operation codes of an input item.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_CATHODE = 1'b1;

  // Configuration reset values.
  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd4;
  localparam logic               CATHODE_RST     = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [LINES_W-1:0] digit_lines;
    logic [LINES_W-1:0] segment_lines;
    logic               last_of_run;
  } out_item_t;

  // Control of one scan step, from the sequencer to the line encoder.
  typedef struct packed {
    logic               clear;
    logic               cathode;
    logic               last;
    logic [DIGIT_W-1:0] position;
    logic [COUNT_W-1:0] count;
  } step_ctrl_t;

  // Standard decimal segment decoder, segment a in bit 0.
  function automatic logic [6:0] seg_decode(input logic [BCD_W-1:0] digit);
    logic [6:0] segs;
    case (digit)
      4'd0:    segs = 7'h3F;
      4'd1:    segs = 7'h06;
      4'd2:    segs = 7'h5B;
      4'd3:    segs = 7'h4F;
      4'd4:    segs = 7'h66;
      4'd5:    segs = 7'h6D;
      4'd6:    segs = 7'h7D;
      4'd7:    segs = 7'h07;
      4'd8:    segs = 7'h7F;
      4'd9:    segs = 7'h6F;
      default: segs = 7'h00;
    endcase
    return segs;
  endfunction

endpackage

`default_nettype wire

@@ design/ssd_div10.sv @@
`default_nettype none

module ssd_div10 (
  input  wire logic [ssd_pkg::VALUE_W-1:0] value,
  output logic      [ssd_pkg::VALUE_W-1:0] quotient,
  output logic      [ssd_pkg::BCD_W-1:0]   digit
);

  logic [2*ssd_pkg::VALUE_W-1:0] product;
  logic [2:0]                    q_lo;

  // Reciprocal multiplication gives the quotient.
  assign product  = {{ssd_pkg::VALUE_W{1'b0}}, value} *
                    {{ssd_pkg::VALUE_W{1'b0}}, ssd_pkg::DIV10_MULT};
  assign quotient = ssd_pkg::VALUE_W'(product >> ssd_pkg::DIV10_SHIFT);

  // The remainder is below ten, so four low bits of v - 10q are enough.
  assign q_lo  = quotient[2:0];
  assign digit = value[ssd_pkg::BCD_W-1:0] - ({q_lo[0], 3'b000} + {q_lo[2:0], 1'b0});

endmodule

`default_nettype wire

@@ design/ssd_encode.sv @@
`default_nettype none

module ssd_encode (
  input  wire ssd_pkg::step_ctrl_t           ctrl,
  input  wire logic [ssd_pkg::BCD_W-1:0]     digit,
  output ssd_pkg::out_item_t                 item
);

  logic [ssd_pkg::LINES_W-1:0] mask;
  logic [ssd_pkg::LINES_W-1:0] select;
  logic [6:0]                  segs;

  // Digit pins within the scanned count, and the one pin scanned now.
  always_comb begin
    mask   = '0;
    select = '0;
    for (int i = 0; i < ssd_pkg::MAX_DIGITS; i++) begin
      mask[i]   = (ssd_pkg::COUNT_W'(i) < ctrl.count);
      select[i] = (ctrl.position == ssd_pkg::DIGIT_W'(i));
    end
  end

  assign segs = ssd_pkg::seg_decode(digit);

  // Apply polarity; a clear drives every line low.
  always_comb begin
    item.last_of_run = ctrl.last;
    if (ctrl.clear) begin
      item.digit_lines   = '0;
      item.segment_lines = '0;
    end else if (ctrl.cathode) begin
      item.digit_lines   = mask & ~select;
      item.segment_lines = {1'b0, segs};
    end else begin
      item.digit_lines   = select;
      item.segment_lines = {1'b1, ~segs};
    end
  end

endmodule

`default_nettype wire

@@ design/seven_segment_scan_driver.sv @@
`default_nettype none

// Multiplexed seven-segment scan driver.
// Input channel: an item (operation, value) is taken at a rising edge where
// start is high and busy is low. A write item is split into decimal digits,
// least significant first, and produces one scan step per shown digit; a
// clear item produces a single step with every line low.
// Result channel: each step appears on out_item for one cycle with out_valid
// high; the receiver cannot stall, so steps follow one per cycle and
// last_of_run marks the final step of an item.
// The first step of an item passes through the sequencer registers and then
// the output register before it reaches the result ports.
// Steps per item: a write item produces the clamped digit count of steps (one
// to eight), a clear item one step; scan steps follow at one per cycle.
// The next item is taken on the cycle the last step of the current one is
// produced, so items run back to back.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 digit
// count, 1 common cathode) at once; write only while the block is idle.
// Reset: rst_n sampled low at a rising edge clears the sequencer and the output strobe
// and restores digit count 4 and common cathode polarity.
module seven_segment_scan_driver (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ssd_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  output ssd_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_we,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [ssd_pkg::COUNT_W-1:0] digit_count_r;
  logic                        cathode_r;
  logic                        active_r, active_nxt;
  logic                        clear_r, clear_nxt;
  logic [ssd_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [ssd_pkg::DIGIT_W-1:0] pos_r, pos_nxt;
  logic                        out_valid_r;
  ssd_pkg::out_item_t          out_item_r;

  logic [ssd_pkg::COUNT_W-1:0] count_eff;
  logic [ssd_pkg::DIGIT_W-1:0] pos_last;
  logic                        step_last;
  logic                        in_accept;
  logic [ssd_pkg::VALUE_W-1:0] quotient;
  logic [ssd_pkg::BCD_W-1:0]   digit;
  ssd_pkg::step_ctrl_t         ctrl;
  ssd_pkg::out_item_t          step_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= ssd_pkg::DIGIT_COUNT_RST;
      cathode_r     <= ssd_pkg::CATHODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssd_pkg::CFG_DIGIT_COUNT:    digit_count_r <= cfg_wdata;
        ssd_pkg::CFG_COMMON_CATHODE: cathode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the digit count to the display size.
  always_comb begin
    if (digit_count_r == '0) begin
      count_eff = ssd_pkg::COUNT_W'(1);
    end else if (digit_count_r > ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS)) begin
      count_eff = ssd_pkg::COUNT_W'(ssd_pkg::MAX_DIGITS);
    end else begin
      count_eff = digit_count_r;
    end
  end

  assign pos_last  = ssd_pkg::DIGIT_W'(count_eff - ssd_pkg::COUNT_W'(1));
  assign step_last = clear_r || (pos_r == pos_last);
  assign busy      = active_r && !step_last;
  assign in_accept = start && !busy;

  // One digit per cycle from the remaining value.
  ssd_div10 u_div10 (
    .value    (value_r),
    .quotient (quotient),
    .digit    (digit)
  );

  always_comb begin
    ctrl.clear    = clear_r;
    ctrl.cathode  = cathode_r;
    ctrl.last     = step_last;
    ctrl.position = pos_r;
    ctrl.count    = count_eff;
  end

  ssd_encode u_encode (
    .ctrl  (ctrl),
    .digit (digit),
    .item  (step_item)
  );

  // Scan sequencer: load a new item or advance to the next digit.
  always_comb begin
    active_nxt = active_r;
    clear_nxt  = clear_r;
    value_nxt  = value_r;
    pos_nxt    = pos_r;
    if (in_accept) begin
      active_nxt = 1'b1;
      clear_nxt  = (in_item.operation == ssd_pkg::OP_CLEAR);
      value_nxt  = in_item.value;
      pos_nxt    = '0;
    end else if (active_r && step_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      value_nxt = quotient;
      pos_nxt   = pos_r + ssd_pkg::DIGIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      clear_r  <= 1'b0;
      pos_r    <= '0;
    end else begin
      active_r <= active_nxt;
      clear_r  <= clear_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= step_item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A step that is not the last of its item is followed by another step.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_of_run |=> out_valid)
    else $error("scan run ended without a last step");

  // Every accepted item shows its first step after the sequencer and output registers.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("accepted item produced no step");

  // While busy, a step is being produced.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("busy without a scan step");

endmodule

`default_nettype wire
